@@ rtl/prank_pkg.sv @@
// ----------------------------------------------------------------------------
// prank_pkg: shared types and constants for the permutation rank block
// Holds the beat types of both directions, the command and status groups
// between controller and datapath, and the factorial table.
// ----------------------------------------------------------------------------
package prank_pkg;

    localparam int ELEM_W = 8;
    localparam int RANK_W = 29;

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic              last;
    } t_prank_in;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              too_long;
    } t_prank_out;

    typedef struct packed {
        logic load;
        logic setup;
        logic mul;
        logic add;
        logic clear;
    } t_prank_cmd;

    typedef struct packed {
        logic ovf;
        logic short_seq;
        logic k_zero;
    } t_prank_sts;

    function automatic logic [RANK_W-1:0] prank_fact(input logic [3:0] k);
        logic [RANK_W-1:0] f;
        case (k)
            4'd0:    f = RANK_W'(1);
            4'd1:    f = RANK_W'(1);
            4'd2:    f = RANK_W'(2);
            4'd3:    f = RANK_W'(6);
            4'd4:    f = RANK_W'(24);
            4'd5:    f = RANK_W'(120);
            4'd6:    f = RANK_W'(720);
            4'd7:    f = RANK_W'(5040);
            4'd8:    f = RANK_W'(40320);
            4'd9:    f = RANK_W'(362880);
            4'd10:   f = RANK_W'(3628800);
            4'd11:   f = RANK_W'(39916800);
            4'd12:   f = RANK_W'(479001600);
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

@@ rtl/prank_dp.sv @@
// ----------------------------------------------------------------------------
// prank_dp: permutation rank datapath
// Holds the sequence and the per-position smaller-after counts, and forms
// the weighted sum one term at a time with one multiplier and one adder.
// ----------------------------------------------------------------------------
module prank_dp #(
    parameter int MAX_LEN    = 12,
    parameter int VALUE_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  prank_pkg::t_prank_in  i_item,
    input  prank_pkg::t_prank_cmd i_cmd,
    output prank_pkg::t_prank_sts o_sts,
    output prank_pkg::t_prank_out o_result
);
    import prank_pkg::*;

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = $clog2(MAX_LEN);

    logic [VALUE_BITS-1:0] r_held [MAX_LEN];
    logic [CW-1:0]         r_cnt  [MAX_LEN];
    logic [LW-1:0]         r_len;
    logic                  r_ovf;
    logic [CW-1:0]         r_k;
    logic [RANK_W-1:0]     r_prod;
    logic [RANK_W-1:0]     r_acc;
    logic [VALUE_BITS-1:0] v;
    logic                  room;

    assign v    = VALUE_BITS'(i_item.element);
    assign room = (r_len < LW'(MAX_LEN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_ovf <= 1'b0;
            for (int i = 0; i < MAX_LEN; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_cmd.clear) begin
            r_len <= '0;
            r_ovf <= 1'b0;
            for (int i = 0; i < MAX_LEN; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_cmd.load && !r_ovf) begin
            if (!room) begin
                r_ovf <= 1'b1;
            end else begin
                for (int i = 0; i < MAX_LEN; i++) begin
                    if (LW'(i) < r_len && r_held[i] > v) begin
                        r_cnt[i] <= r_cnt[i] + CW'(1);
                    end
                end
                r_len <= r_len + LW'(1);
            end
        end else if (i_cmd.mul) begin
            for (int i = 0; i < MAX_LEN - 1; i++) begin
                r_cnt[i] <= r_cnt[i+1];
            end
            r_cnt[MAX_LEN-1] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !r_ovf && room) begin
            for (int i = 0; i < MAX_LEN; i++) begin
                if (LW'(i) == r_len) begin
                    r_held[i] <= v;
                end
            end
        end
        if (i_cmd.setup) begin
            r_k   <= CW'(r_len - LW'(1));
            r_acc <= '0;
        end
        if (i_cmd.mul) begin
            r_prod <= RANK_W'(r_cnt[0]) * prank_fact(4'(r_k));
            r_k    <= r_k - CW'(1);
        end
        if (i_cmd.add) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign o_sts.ovf       = r_ovf;
    assign o_sts.short_seq = (r_len <= LW'(1));
    assign o_sts.k_zero    = (r_k == '0);

    assign o_result.rank     = r_ovf ? '0 : r_acc;
    assign o_result.too_long = r_ovf;

`ifndef ASSERT_OFF
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_len == '0) && !r_ovf)
        else $error("state not cleared after result");
    a_len_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && !i_cmd.clear && !r_ovf && room) |=> r_len == $past(r_len) + LW'(1))
        else $error("length did not advance on stored beat");
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_len == LW'(MAX_LEN))
        else $error("overflow flagged before table was full");
`endif

endmodule

@@ rtl/prank_ctrl.sv @@
// ----------------------------------------------------------------------------
// prank_ctrl: permutation rank controller
// Takes beats while idle and, after the closing beat, steps the datapath
// through the weighted sum and strobes the result for one cycle.
// ----------------------------------------------------------------------------
module prank_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  i_last,
    input  prank_pkg::t_prank_sts i_sts,
    output prank_pkg::t_prank_cmd o_cmd,
    output logic                  busy,
    output logic                  o_valid
);
    import prank_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_MUL,
        S_ADD,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    logic   r_valid;
    logic   take;

    assign take = start && !r_busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (take && i_last) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                if (i_sts.ovf || i_sts.short_seq) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                if (i_sts.k_zero) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_valid <= (n_state == S_OUT);
        end
    end

    assign o_cmd.load  = take;
    assign o_cmd.setup = (r_state == S_SETUP);
    assign o_cmd.mul   = (r_state == S_MUL);
    assign o_cmd.add   = (r_state == S_ADD);
    assign o_cmd.clear = (r_state == S_OUT);

    assign busy    = r_busy;
    assign o_valid = r_valid;

`ifndef ASSERT_OFF
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_last) |=> busy)
        else $error("closing beat did not raise busy");
    a_valid_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy && !o_cmd.load)
        else $error("result strobe outside busy window");
`endif

endmodule

@@ rtl/permutation_rank.sv @@
// ----------------------------------------------------------------------------
// permutation_rank: lexicographic rank of a sequence (Lehmer code)
// One element is taken per beat whenever busy is low; the beat with last
// set closes the sequence. busy then stays high while the shared multiplier
// and adder form the weighted sum one term at a time, and o_valid strobes
// the result for one cycle (the sum is skipped when the sequence has one
// element or was too long). The receiver cannot stall, so the result must
// be captured in that cycle; the next sequence may start the cycle after.
// ----------------------------------------------------------------------------
module permutation_rank #(
    parameter int MAX_LEN    = 12,
    parameter int VALUE_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  prank_pkg::t_prank_in  i_item,
    output logic                  busy,
    output logic                  o_valid,
    output prank_pkg::t_prank_out o_result
);
    import prank_pkg::*;

    t_prank_cmd cmd;
    t_prank_sts sts;

    prank_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_last  (i_item.last),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    prank_dp #(
        .MAX_LEN    (MAX_LEN),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result)
    );

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for permutation_rank
// Sends sequences one element per beat with bursts and gaps on the sender
// side, predicts the rank of every closed sequence with a model of its own,
// and compares each result strobe field by field with the oldest prediction.
// A short table of directed sequences comes first, then random sequences.
// ----------------------------------------------------------------------------
module tb_top;

    import prank_pkg::*;

    localparam int MAX_ELEMS = 12;
    localparam int BEAT_GOAL = 950;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int FULL_RANK = 479001599;

    typedef struct packed {
        logic [7:0]        element;
        logic              last;
        logic [4:0]        reps;
        logic              typed;
        logic [RANK_W-1:0] rank;
        logic              too_long;
    } t_row;

    localparam int ROWS = 23;
    localparam t_row SCRIPT [ROWS] = '{
        '{8'h00, 1'b1, 5'd1,  1'b1, 29'd0, 1'b0},
        '{8'hFF, 1'b1, 5'd1,  1'b1, 29'd0, 1'b0},
        '{8'h01, 1'b0, 5'd1,  1'b0, 29'd0, 1'b0},
        '{8'h00, 1'b1, 5'd1,  1'b1, 29'd1, 1'b0},
        '{8'hFF, 1'b0, 5'd1,  1'b0, 29'd0, 1'b0},
        '{8'hC8, 1'b0, 5'd1,  1'b0, 29'd0, 1'b0},
        '{8'hAA, 1'b0, 5'd1,  1'b0, 29'd0, 1'b0},
        '{8'h96, 1'b0, 5'd1,  1'b0, 29'd0, 1'b0},
        '{8'h80, 1'b0, 5'd1,  1'b0, 29'd0, 1'b0},
        '{8'h64, 1'b0, 5'd1,  1'b0, 29'd0, 1'b0},
        '{8'h55, 1'b0, 5'd1,  1'b0, 29'd0, 1'b0},
        '{8'h40, 1'b0, 5'd1,  1'b0, 29'd0, 1'b0},
        '{8'h20, 1'b0, 5'd1,  1'b0, 29'd0, 1'b0},
        '{8'h10, 1'b0, 5'd1,  1'b0, 29'd0, 1'b0},
        '{8'h01, 1'b0, 5'd1,  1'b0, 29'd0, 1'b0},
        '{8'h00, 1'b1, 5'd1,  1'b1, 29'(FULL_RANK), 1'b0},
        '{8'h07, 1'b0, 5'd2,  1'b0, 29'd0, 1'b0},
        '{8'h07, 1'b1, 5'd1,  1'b1, 29'd0, 1'b0},
        '{8'h5A, 1'b0, 5'd12, 1'b0, 29'd0, 1'b0},
        '{8'hA5, 1'b1, 5'd1,  1'b1, 29'd0, 1'b1},
        '{8'h03, 1'b0, 5'd1,  1'b0, 29'd0, 1'b0},
        '{8'h01, 1'b0, 5'd1,  1'b0, 29'd0, 1'b0},
        '{8'h02, 1'b1, 5'd1,  1'b0, 29'd0, 1'b0}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       start;
    t_prank_in  i_item;
    logic       busy;
    logic       o_valid;
    t_prank_out o_result;

    logic [7:0] seen_values [MAX_ELEMS];
    logic [3:0] smaller_later [MAX_ELEMS];
    logic [3:0] seq_len;
    logic       seq_overflow;

    t_prank_out rank_due [$];
    logic       typed_on;
    t_prank_out typed_res;

    int beats_sent;
    int beats_taken;
    int seqs_closed;
    int overflows_closed;
    int fail_count;
    int cycle_count;
    int burst_left;
    bit no_gaps;

    permutation_rank i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [63:0] factorial(input int k);
        logic [63:0] f;
        f = 64'd1;
        for (int j = 2; j <= k; j++) begin
            f = f * j;
        end
        return f;
    endfunction

    function automatic t_prank_out lehmer_rank();
        logic [63:0] sum;
        t_prank_out  r;
        sum = 64'd0;
        for (int j = 0; j + 1 < int'(seq_len); j++) begin
            sum = sum + smaller_later[j] * factorial(int'(seq_len) - 1 - j);
        end
        r.rank     = sum[RANK_W-1:0];
        r.too_long = 1'b0;
        return r;
    endfunction

    task automatic clear_sequence();
        for (int j = 0; j < MAX_ELEMS; j++) begin
            seen_values[j]   = '0;
            smaller_later[j] = '0;
        end
        seq_len      = '0;
        seq_overflow = 1'b0;
    endtask

    task automatic take_element(input t_prank_in it);
        t_prank_out r;
        if (!seq_overflow) begin
            if (seq_len >= MAX_ELEMS) begin
                seq_overflow = 1'b1;
            end else begin
                for (int j = 0; j < int'(seq_len); j++) begin
                    if (seen_values[j] > it.element) begin
                        smaller_later[j] = smaller_later[j] + 4'd1;
                    end
                end
                seen_values[seq_len] = it.element;
                seq_len = seq_len + 4'd1;
            end
        end
        if (it.last) begin
            if (seq_overflow) begin
                r.rank     = '0;
                r.too_long = 1'b1;
                overflows_closed++;
            end else begin
                r = lehmer_rank();
            end
            rank_due.push_back(typed_on ? typed_res : r);
            seqs_closed++;
            clear_sequence();
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, rank_due.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_prank_out want;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            if (rank_due.size() == 0) begin
                $display("%0t: unexpected result beat rank=%0d too_long=%b",
                         $time, o_result.rank, o_result.too_long);
                fail_count++;
            end else begin
                want = rank_due.pop_front();
                if (o_result.rank !== want.rank) begin
                    $display("%0t: rank expected %0d actual %0d",
                             $time, want.rank, o_result.rank);
                    fail_count++;
                end
                if (o_result.too_long !== want.too_long) begin
                    $display("%0t: too_long expected %b actual %b",
                             $time, want.too_long, o_result.too_long);
                    fail_count++;
                end
            end
        end
        if (i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) begin
            beats_taken++;
            take_element(i_item);
        end
    end

    task automatic pause_sender(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start  <= 1'b0;
            i_item <= t_prank_in'($urandom);
        end
    endtask

    task automatic send_beat(input t_prank_in it, input logic check_typed,
                             input t_prank_out typed_value);
        if (burst_left == 0) begin
            no_gaps    = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(1, 24);
            if (!no_gaps) begin
                pause_sender($urandom_range(1, 6));
            end
        end
        burst_left--;
        @(negedge i_clk);
        start     <= 1'b1;
        i_item    <= it;
        typed_on  = check_typed;
        typed_res = typed_value;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        beats_sent++;
    endtask

    task automatic random_sequence();
        int         len;
        int         top;
        t_prank_in  it;
        t_prank_out none;
        none = '0;
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_ELEMS + 1, 16)
                                           : $urandom_range(1, MAX_ELEMS);
        top  = ($urandom_range(0, 1) == 0) ? 255 : $urandom_range(1, 7);
        for (int j = 0; j < len; j++) begin
            it.element = 8'($urandom_range(0, top));
            it.last    = (j == len - 1);
            send_beat(it, 1'b0, none);
        end
    endtask

    initial begin
        t_prank_in  it;
        t_prank_out typed_value;
        start        <= 1'b0;
        i_item       <= '0;
        i_rst_n      <= 1'b0;
        typed_on     = 1'b0;
        typed_res    = '0;
        beats_sent   = 0;
        beats_taken  = 0;
        seqs_closed  = 0;
        overflows_closed = 0;
        fail_count   = 0;
        cycle_count  = 0;
        burst_left   = 0;
        clear_sequence();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < ROWS; r++) begin
            for (int k = 0; k < int'(SCRIPT[r].reps); k++) begin
                it.element           = SCRIPT[r].element;
                it.last              = SCRIPT[r].last;
                typed_value.rank     = SCRIPT[r].rank;
                typed_value.too_long = SCRIPT[r].too_long;
                send_beat(it, SCRIPT[r].typed, typed_value);
            end
        end

        while (beats_sent < BEAT_GOAL) begin
            random_sequence();
        end

        pause_sender(1);
        while (rank_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d element beats taken, %0d sequences ranked, %0d of them too long.",
                 beats_taken, seqs_closed, overflows_closed);
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

@@ permutation_rank.f @@
rtl/prank_pkg.sv
rtl/prank_dp.sv
rtl/prank_ctrl.sv
rtl/permutation_rank.sv
test/tb_top.sv
